@@ rtl/core/arpt_pkg.sv @@
package arpt_pkg;
    localparam logic [1:0] KIND_ARP_REQ = 2'd0;
    localparam logic [1:0] KIND_UNREACH = 2'd1;
    localparam logic [1:0] KIND_ACCEPT = 2'd2;
    localparam logic [1:0] KIND_DROP = 2'd3;
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_TICK = 1'b1;
    localparam logic [3:0] MAX_TRIES_RESET = 4'd5;
endpackage

@@ rtl/core/arp_pending_request_table.sv @@
// Pending ARP resolution table. An enqueue request searches the entries one per cycle, then gives
// one result. A tick request walks the entries one per cycle while the output is not stalled;
// an entry that gives up emits one result per queued handle, and a surviving entry is copied down
// one handle per cycle when an earlier entry was removed. The handle store is a memory with one
// write and one registered read port, so the walk over handles sets the tick duration. The block
// takes no new request until the last result of the current one has been taken.
// max_tries may be written only while idle.
module arp_pending_request_table #(
    parameter int ENTRIES = 8,
    parameter int PACKETS_PER_ENTRY = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [31:0] s_target_ip,
    input  logic [3:0]  s_iface,
    input  logic [7:0]  s_pkt_handle,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [31:0] m_out_ip,
    output logic [3:0]  m_out_iface,
    output logic [7:0]  m_out_handle,
    output logic        m_last
);
    import arpt_pkg::*;

    localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PW = (PACKETS_PER_ENTRY > 1) ? $clog2(PACKETS_PER_ENTRY) : 1;
    localparam int CW = $clog2(PACKETS_PER_ENTRY + 1);
    localparam int EC = $clog2(ENTRIES + 1);
    localparam int DEPTH = ENTRIES * PACKETS_PER_ENTRY;
    localparam int AW = EW + PW;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SRCH = 3'd1;
    localparam logic [2:0] ST_WALK = 3'd2;
    localparam logic [2:0] ST_DUMP = 3'd3;
    localparam logic [2:0] ST_COPY = 3'd4;
    localparam logic [2:0] ST_OUT = 3'd5;
    localparam logic [2:0] ST_TEND = 3'd6;

    logic [2:0] state_reg;
    logic [3:0] max_tries_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [31:0] ip_reg [ENTRIES];
    logic [3:0] port_reg [ENTRIES];
    logic [3:0] tries_reg [ENTRIES];
    logic [CW-1:0] cnt_reg [ENTRIES];
    logic [7:0] mem [DEPTH];
    logic [7:0] rd_reg;

    logic [31:0] ip_in_reg;
    logic [3:0] if_in_reg;
    logic [7:0] h_in_reg;
    logic [EC-1:0] i_reg, w_reg;
    logic [CW-1:0] p_reg;
    logic rd_pend_reg;
    // pending held result (tick): emitted when next result known or at end
    logic hold_v_reg;
    logic [1:0] hk_reg;
    logic [31:0] hip_reg;
    logic [3:0] hif_reg;
    logic [7:0] hh_reg;

    logic [EW-1:0] ie, we;
    assign ie = i_reg[EW-1:0];
    assign we = w_reg[EW-1:0];

    logic out_free;
    assign out_free = !m_valid || m_ready;
    assign s_ready = (state_reg == ST_IDLE) && out_free;

    logic [AW-1:0] rd_addr;
    logic rd_en;
    logic wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0] wr_data;

    function automatic logic [AW-1:0] addr(input logic [EW-1:0] e, input logic [CW-1:0] p);
        addr = AW'(e * PACKETS_PER_ENTRY) + AW'(p);
    endfunction

    always_ff @(posedge aclk) begin
        if (rd_en) rd_reg <= mem[rd_addr];
        if (wr_en) mem[wr_addr] <= wr_data;
    end

    logic at_end;
    assign at_end = (i_reg == EC'(ENTRIES)) || !valid_reg[ie];

    always_comb begin
        rd_en = 1'b0;
        rd_addr = addr(ie, p_reg);
        wr_en = 1'b0;
        wr_addr = addr(we, p_reg - CW'(1));
        wr_data = rd_reg;
        if (state_reg == ST_DUMP || state_reg == ST_COPY) begin
            rd_en = (p_reg < cnt_reg[ie]) && (state_reg == ST_COPY || out_free || !hold_v_reg
                     || !rd_pend_reg);
            wr_en = (state_reg == ST_COPY) && rd_pend_reg;
        end
        if (state_reg == ST_SRCH) begin
            wr_data = h_in_reg;
            if (at_end) begin
                wr_en = (i_reg != EC'(ENTRIES));
                wr_addr = addr(ie, '0);
            end else begin
                wr_en = (ip_reg[ie] == ip_in_reg) && (cnt_reg[ie] < CW'(PACKETS_PER_ENTRY));
                wr_addr = addr(ie, cnt_reg[ie]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            max_tries_reg <= MAX_TRIES_RESET;
            valid_reg <= '0;
            m_valid <= 1'b0;
            hold_v_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
            for (int k = 0; k < ENTRIES; k++) begin
                tries_reg[k] <= '0;
                cnt_reg[k] <= '0;
            end
        end else begin
            if (cfg_we) max_tries_reg <= cfg_wdata;
            if (m_valid && m_ready) m_valid <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        ip_in_reg <= s_target_ip;
                        if_in_reg <= s_iface;
                        h_in_reg <= s_pkt_handle;
                        i_reg <= '0;
                        w_reg <= '0;
                        state_reg <= (s_op == OP_TICK) ? ST_WALK : ST_SRCH;
                    end
                end
                ST_SRCH: begin
                    if (at_end) begin
                        if (i_reg == EC'(ENTRIES)) begin
                            hk_reg <= KIND_DROP;
                            hif_reg <= if_in_reg;
                        end else begin
                            valid_reg[ie] <= 1'b1;
                            ip_reg[ie] <= ip_in_reg;
                            port_reg[ie] <= if_in_reg;
                            tries_reg[ie] <= '0;
                            cnt_reg[ie] <= CW'(1);
                            hk_reg <= KIND_ACCEPT;
                            hif_reg <= if_in_reg;
                        end
                        state_reg <= ST_OUT;
                    end else if (ip_reg[ie] == ip_in_reg) begin
                        hif_reg <= port_reg[ie];
                        if (cnt_reg[ie] >= CW'(PACKETS_PER_ENTRY)) begin
                            hk_reg <= KIND_DROP;
                        end else begin
                            cnt_reg[ie] <= cnt_reg[ie] + CW'(1);
                            hk_reg <= KIND_ACCEPT;
                        end
                        state_reg <= ST_OUT;
                    end else begin
                        i_reg <= i_reg + EC'(1);
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_valid <= 1'b1;
                        m_kind <= hk_reg;
                        m_out_ip <= ip_in_reg;
                        m_out_iface <= hif_reg;
                        m_out_handle <= h_in_reg;
                        m_last <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_WALK: begin
                    if (at_end) begin
                        state_reg <= ST_TEND;
                    end else if (!hold_v_reg || out_free) begin
                        if (hold_v_reg) begin
                            m_valid <= 1'b1;
                            m_kind <= hk_reg;
                            m_out_ip <= hip_reg;
                            m_out_iface <= hif_reg;
                            m_out_handle <= hh_reg;
                            m_last <= 1'b0;
                            hold_v_reg <= 1'b0;
                        end
                        p_reg <= '0;
                        rd_pend_reg <= 1'b0;
                        if (tries_reg[ie] < max_tries_reg) begin
                            hold_v_reg <= 1'b1;
                            hk_reg <= KIND_ARP_REQ;
                            hip_reg <= ip_reg[ie];
                            hif_reg <= port_reg[ie];
                            hh_reg <= '0;
                            valid_reg[we] <= 1'b1;
                            ip_reg[we] <= ip_reg[ie];
                            port_reg[we] <= port_reg[ie];
                            tries_reg[we] <= tries_reg[ie] + 4'd1;
                            cnt_reg[we] <= cnt_reg[ie];
                            if (w_reg != i_reg) begin
                                state_reg <= ST_COPY;
                            end else begin
                                i_reg <= i_reg + EC'(1);
                                w_reg <= w_reg + EC'(1);
                            end
                        end else begin
                            state_reg <= ST_DUMP;
                        end
                    end
                end
                ST_COPY: begin
                    if (rd_en) p_reg <= p_reg + CW'(1);
                    rd_pend_reg <= rd_en;
                    if (!rd_en && !rd_pend_reg) begin
                        i_reg <= i_reg + EC'(1);
                        w_reg <= w_reg + EC'(1);
                        state_reg <= ST_WALK;
                    end
                end
                ST_DUMP: begin
                    if (rd_pend_reg && (!hold_v_reg || out_free)) begin
                        if (hold_v_reg) begin
                            m_valid <= 1'b1;
                            m_kind <= hk_reg;
                            m_out_ip <= hip_reg;
                            m_out_iface <= hif_reg;
                            m_out_handle <= hh_reg;
                            m_last <= 1'b0;
                        end
                        hold_v_reg <= 1'b1;
                        hk_reg <= KIND_UNREACH;
                        hip_reg <= ip_reg[ie];
                        hif_reg <= port_reg[ie];
                        hh_reg <= rd_reg;
                    end
                    if (rd_en) p_reg <= p_reg + CW'(1);
                    if (rd_en || (rd_pend_reg && (!hold_v_reg || out_free)))
                        rd_pend_reg <= rd_en;
                    if (!rd_en && !rd_pend_reg) begin
                        i_reg <= i_reg + EC'(1);
                        state_reg <= ST_WALK;
                    end
                end
                ST_TEND: begin
                    for (int k = 0; k < ENTRIES; k++) begin
                        if (EC'(k) >= w_reg) begin
                            valid_reg[k] <= 1'b0;
                            tries_reg[k] <= '0;
                            cnt_reg[k] <= '0;
                        end
                    end
                    if (!hold_v_reg) begin
                        state_reg <= ST_IDLE;
                    end else if (out_free) begin
                        m_valid <= 1'b1;
                        m_kind <= hk_reg;
                        m_out_ip <= hip_reg;
                        m_out_iface <= hif_reg;
                        m_out_handle <= hh_reg;
                        m_last <= 1'b1;
                        hold_v_reg <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == ST_IDLE) else $error("ready outside idle");
    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_kind) && $stable(m_out_handle))
        else $error("result changed while stalled");
    a_enq_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_kind == KIND_ACCEPT || m_kind == KIND_DROP)) |-> m_last)
        else $error("enqueue result without last");
    a_wr_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COPY) |-> w_reg < i_reg) else $error("copy without gap");
`endif
endmodule

@@ verif/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import arpt_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] ip;
        logic [3:0]  iface;
        logic [7:0]  handle;
        logic        last;
    } notice_t;

    class arp_table_scoreboard;
        logic [3:0]  max_tries;
        int          n_used;
        logic [31:0] ent_ip[8];
        logic [3:0]  ent_port[8];
        logic [3:0]  ent_tries[8];
        logic [7:0]  ent_handles[8][8];
        int          ent_count[8];
        notice_t     pending_notices[$];
        int          errors;
        int          n_checked;
        int          n_unreach;
        int          n_drop;

        function new();
            max_tries = MAX_TRIES_RESET;
            n_used = 0;
            errors = 0;
            n_checked = 0;
            n_unreach = 0;
            n_drop = 0;
        endfunction

        function void push(logic [1:0] k, logic [31:0] ip, logic [3:0] p, logic [7:0] h,
                           logic l);
            notice_t r;
            r.kind = k;
            r.ip = ip;
            r.iface = p;
            r.handle = h;
            r.last = l;
            pending_notices.push_back(r);
        endfunction

        function void note_request(logic op, logic [31:0] ip, logic [3:0] ifc, logic [7:0] h);
            int slot;
            int w;
            int first;
            slot = -1;
            if (op == OP_ENQUEUE) begin
                for (int i = 0; i < n_used; i++)
                    if (ent_ip[i] == ip && slot < 0) slot = i;
                if (slot < 0) begin
                    if (n_used >= 8) begin
                        push(KIND_DROP, ip, ifc, h, 1'b1);
                        return;
                    end
                    slot = n_used;
                    n_used++;
                    ent_ip[slot] = ip;
                    ent_port[slot] = ifc;
                    ent_tries[slot] = 0;
                    ent_count[slot] = 0;
                end
                if (ent_count[slot] >= 8) begin
                    push(KIND_DROP, ip, ent_port[slot], h, 1'b1);
                    return;
                end
                ent_handles[slot][ent_count[slot]] = h;
                ent_count[slot]++;
                push(KIND_ACCEPT, ip, ent_port[slot], h, 1'b1);
            end else begin
                w = 0;
                first = pending_notices.size();
                for (int i = 0; i < n_used; i++) begin
                    if (ent_tries[i] < max_tries) begin
                        push(KIND_ARP_REQ, ent_ip[i], ent_port[i], 8'd0, 1'b0);
                        ent_tries[i]++;
                        ent_ip[w] = ent_ip[i];
                        ent_port[w] = ent_port[i];
                        ent_tries[w] = ent_tries[i];
                        ent_count[w] = ent_count[i];
                        ent_handles[w] = ent_handles[i];
                        w++;
                    end else begin
                        for (int p = 0; p < ent_count[i]; p++)
                            push(KIND_UNREACH, ent_ip[i], ent_port[i], ent_handles[i][p], 1'b0);
                    end
                end
                n_used = w;
                if (pending_notices.size() > first)
                    pending_notices[pending_notices.size() - 1].last = 1'b1;
            end
        endfunction

        function void check_result(notice_t got);
            notice_t exp;
            n_checked++;
            if (got.kind == KIND_UNREACH) n_unreach++;
            if (got.kind == KIND_DROP) n_drop++;
            if (pending_notices.size() == 0) begin
                $display("%0t: unexpected result kind=%0d ip=%h", $time, got.kind, got.ip);
                errors++;
                return;
            end
            exp = pending_notices.pop_front();
            if (got.kind !== exp.kind) begin
                $display("%0t: kind exp %0d got %0d", $time, exp.kind, got.kind);
                errors++;
            end
            if (got.ip !== exp.ip) begin
                $display("%0t: ip exp %h got %h", $time, exp.ip, got.ip);
                errors++;
            end
            if (got.iface !== exp.iface) begin
                $display("%0t: iface exp %0d got %0d", $time, exp.iface, got.iface);
                errors++;
            end
            if (got.handle !== exp.handle) begin
                $display("%0t: handle exp %0d got %0d", $time, exp.handle, got.handle);
                errors++;
            end
            if (got.last !== exp.last) begin
                $display("%0t: last exp %0d got %0d", $time, exp.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [3:0]  cfg_wdata = 4'd0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_op = 1'b0;
    logic [31:0] s_target_ip = 32'd0;
    logic [3:0]  s_iface = 4'd0;
    logic [7:0]  s_pkt_handle = 8'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_kind;
    logic [31:0] m_out_ip;
    logic [3:0]  m_out_iface;
    logic [7:0]  m_out_handle;
    logic        m_last;

    arp_table_scoreboard sb = new();
    int  burst_left = 0;
    int  gap_left = 0;
    bit  hold_off = 1'b0;
    bit  stall_mode = 1'b0;
    int  n_requests = 0;
    logic [31:0] ip_pool[16];

    always #1 aclk = ~aclk;

    arp_pending_request_table #(.ENTRIES(8), .PACKETS_PER_ENTRY(8)) uut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op), .s_target_ip(s_target_ip),
        .s_iface(s_iface), .s_pkt_handle(s_pkt_handle), .m_valid(m_valid),
        .m_ready(m_ready), .m_kind(m_kind), .m_out_ip(m_out_ip),
        .m_out_iface(m_out_iface), .m_out_handle(m_out_handle), .m_last(m_last)
    );

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result({m_kind, m_out_ip, m_out_iface, m_out_handle, m_last});
        if (!aresetn || hold_off)
            m_ready <= 1'b0;
        else if (stall_mode)
            m_ready <= ($urandom_range(0, 3) == 0);
        else
            m_ready <= ($urandom_range(0, 9) != 0);
    end

    task automatic send_request(logic op, logic [31:0] ip, logic [3:0] ifc, logic [7:0] h);
        if (burst_left == 0) begin
            gap_left = $urandom_range(0, 2) == 0 ? $urandom_range(1, 12) : 0;
            burst_left = $urandom_range(1, 20);
        end
        repeat (gap_left + 1) @(posedge aclk);
        gap_left = 0;
        burst_left--;
        s_valid <= 1'b1;
        s_op <= op;
        s_target_ip <= ip;
        s_iface <= ifc;
        s_pkt_handle <= h;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(op, ip, ifc, h);
        n_requests++;
        s_valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending_notices.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_max_tries(logic [3:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.max_tries = v;
    endtask

    task automatic random_phase(int n, int ip_span);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 4) == 0)
                send_request(OP_TICK, $urandom, 4'($urandom), 8'($urandom));
            else if ($urandom_range(0, 9) == 0)
                send_request(OP_ENQUEUE, $urandom, 4'($urandom), 8'($urandom));
            else
                send_request(OP_ENQUEUE, ip_pool[$urandom_range(0, ip_span - 1)],
                             4'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        for (int i = 0; i < 16; i++) ip_pool[i] = $urandom;
        ip_pool[0] = 32'h0000_0000;
        ip_pool[1] = 32'hFFFF_FFFF;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_request(OP_TICK, 32'h0, 4'h0, 8'h0);
        send_request(OP_ENQUEUE, 32'h0, 4'h0, 8'h00);
        send_request(OP_ENQUEUE, 32'hFFFF_FFFF, 4'hF, 8'hFF);
        send_request(OP_ENQUEUE, 32'hFFFF_FFFF, 4'h3, 8'h5A);
        for (int i = 0; i < 7; i++)
            send_request(OP_ENQUEUE, 32'h0, 4'h7, 8'(8'hA5 + i));
        for (int i = 2; i < 9; i++)
            send_request(OP_ENQUEUE, ip_pool[i], 4'(i), 8'(i));
        for (int i = 0; i < 6; i++)
            send_request(OP_TICK, 32'h0, 4'h0, 8'h0);
        send_request(OP_TICK, 32'h0, 4'h0, 8'h0);

        write_max_tries(4'd0);
        send_request(OP_ENQUEUE, ip_pool[3], 4'h2, 8'h11);
        send_request(OP_TICK, 32'h0, 4'h0, 8'h0);

        write_max_tries(4'd1);
        random_phase(70, 4);
        write_max_tries(4'd15);
        random_phase(60, 10);

        drain();
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end
            random_phase(20, 6);
        join

        write_max_tries(4'd3);
        stall_mode = 1'b1;
        random_phase(80, 12);
        stall_mode = 1'b0;
        write_max_tries(4'd2);
        random_phase(80, 16);
        for (int i = 0; i < 16; i++) send_request(OP_TICK, 32'h0, 4'h0, 8'h0);

        drain();
        $display("Sent %0d requests; checked %0d results (%0d unreachable, %0d dropped).",
                 n_requests, sb.n_checked, sb.n_unreach, sb.n_drop);
        $display("max_tries covered 0, 1, 2, 3, 5 and 15, with a long receiver hold-off.");
        if (sb.errors == 0 && sb.pending_notices.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #2000000;
        $display("Timed out");
        $display("DONE: errors detected");
        $finish;
    end
endmodule

@@ sim.f @@
rtl/core/arpt_pkg.sv
rtl/core/arp_pending_request_table.sv
verif/tb.sv
